/* design/button_debounce_long_press_volume_defines.svh */
// ----------------------------------------------------------------------------
// Button debounce / long press / volume: assertion macros
// Shared assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_VOLUME_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_VOLUME_DEFINES_SVH

// generic clocked assertion with active-low reset
`define BDLPV_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define BDLPV_ASSERT(label, prop, msg) \
    `BDLPV_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

/* design/bdlpv_pkg.sv */
// ----------------------------------------------------------------------------
// Button debounce / long press / volume: package
// Payload types, register indexes and reset constants.
// ----------------------------------------------------------------------------
package bdlpv_pkg;

    localparam int TIME_WIDTH_DEFAULT = 32;
    localparam int NOW_WIDTH          = 32;
    localparam int CFG_ADDR_WIDTH     = 2;
    localparam int CFG_DATA_WIDTH     = 16;

    localparam logic [7:0]  DEBOUNCE_RESET = 8'd35;
    localparam logic [15:0] HOLD_RESET     = 16'd2000;
    localparam logic [3:0]  STEP_RESET     = 4'd1;
    localparam logic [3:0]  MAX_RESET      = 4'd10;
    localparam logic [3:0]  VOL_CEIL       = 4'd10;
    localparam logic [3:0]  VOL_RESET      = 4'd8;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_HOLD     = 2'd1,
        REG_STEP     = 2'd2,
        REG_MAX      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                 power_level;
        logic                 up_level;
        logic                 down_level;
        logic [NOW_WIDTH-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0] volume_level;
        logic       system_active;
        logic       power_toggled;
        logic       volume_up_pressed;
        logic       volume_down_pressed;
    } out_item_t;

    // debouncer status for the current request
    typedef struct packed {
        logic stable;  // stable level after this request
        logic press;   // stable level went to pressed now
    } deb_status_t;

endpackage

/* design/bdlpv_debounce.sv */
// ----------------------------------------------------------------------------
// Button debouncer
// Holds one button's stable level and last change time; reports the new
// stable level and a press event for the request being processed.
// ----------------------------------------------------------------------------
module bdlpv_debounce #(
    parameter int TIME_WIDTH = bdlpv_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic                    raw,
    input  logic [TIME_WIDTH-1:0]   now,
    input  logic [7:0]              deb_limit,
    output bdlpv_pkg::deb_status_t  status
);

    logic                  stable_reg;
    logic                  stable_next;
    logic [TIME_WIDTH-1:0] change_time_reg;
    logic [TIME_WIDTH-1:0] change_time_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  differs;
    logic                  changed;

    always_comb begin
        elapsed          = now - change_time_reg;
        differs          = (raw != stable_reg);
        changed          = differs && (elapsed >= TIME_WIDTH'(deb_limit));
        stable_next      = changed ? raw : stable_reg;
        change_time_next = (!differs || changed) ? now : change_time_reg;
        status.stable    = stable_next;
        status.press     = changed && !raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_reg      <= 1'b1;
            change_time_reg <= '0;
        end else if (advance) begin
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

/* design/button_debounce_long_press_volume.sv */
// ----------------------------------------------------------------------------
// Button debounce with long-press power toggle and stepped volume
// Top level: input register, one pass of decision logic, result register.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one sample of the three active-low buttons
//   plus a millisecond timestamp. Every sample yields exactly one result on
//   m_valid/m_ready/m_data: volume, active flag and one-shot event flags.
//   cfg_wr_en/cfg_addr/cfg_data write debounce time, hold time, volume step
//   and volume maximum; write only while no request is in flight.
// Path: a request waits in the input register and moves to the result
//   register, which drives m_valid, once the result register is free.
// Throughput: one request per cycle while m_ready is high; the input and
//   result registers each hold one request, and the decision logic runs in
//   the cycle the input register hands its request to the result register.
// Stall: while m_ready is low the result holds; one more request is taken
//   into the input register, then s_ready drops until the result drains.
// Reset (aresetn low, synchronous): buttons released, volume 8, active,
//   registers at their defaults, both registers empty.
// ----------------------------------------------------------------------------
module button_debounce_long_press_volume #(
    parameter int TIME_WIDTH = bdlpv_pkg::TIME_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bdlpv_pkg::in_item_t                   s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output bdlpv_pkg::out_item_t                  m_data,
    input  logic                                  cfg_wr_en,
    input  logic [bdlpv_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [bdlpv_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic                  in_valid_reg;
    bdlpv_pkg::in_item_t   in_item_reg;
    logic                  out_valid_reg;
    bdlpv_pkg::out_item_t  out_item_reg;
    bdlpv_pkg::out_item_t  out_item_next;
    logic                  fire;

    logic [7:0]  debounce_reg;
    logic [15:0] hold_reg;
    logic [3:0]  step_reg;
    logic [3:0]  max_reg;

    logic [TIME_WIDTH-1:0] press_time_reg;
    logic [TIME_WIDTH-1:0] press_time_next;
    logic                  long_done_reg;
    logic                  long_done_next;
    logic                  active_reg;
    logic                  active_next;
    logic [3:0]            volume_reg;
    logic [3:0]            volume_next;

    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] held;
    logic                  toggle;
    logic [3:0]            top_vol;
    logic [4:0]            up_sum;
    logic [3:0]            vol_up;

    bdlpv_pkg::deb_status_t pwr_st;
    bdlpv_pkg::deb_status_t up_st;
    bdlpv_pkg::deb_status_t dn_st;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;
    assign now     = TIME_WIDTH'(in_item_reg.now_ms);

    bdlpv_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_power (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (fire),
        .raw         (in_item_reg.power_level),
        .now         (now),
        .deb_limit   (debounce_reg),
        .status      (pwr_st)
    );

    bdlpv_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_up (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (fire),
        .raw         (in_item_reg.up_level),
        .now         (now),
        .deb_limit   (debounce_reg),
        .status      (up_st)
    );

    bdlpv_debounce #(.TIME_WIDTH(TIME_WIDTH)) u_deb_down (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (fire),
        .raw         (in_item_reg.down_level),
        .now         (now),
        .deb_limit   (debounce_reg),
        .status      (dn_st)
    );

    // power long press
    always_comb begin
        press_time_next = pwr_st.press ? now : press_time_reg;
        long_done_next  = pwr_st.press ? 1'b0 : long_done_reg;
        held            = now - press_time_next;
        toggle          = !pwr_st.stable && !long_done_next &&
                          (held >= TIME_WIDTH'(hold_reg));
        if (toggle) begin
            long_done_next = 1'b1;
        end
        active_next = active_reg ^ toggle;
    end

    // volume: up first, then down
    always_comb begin
        top_vol = (max_reg > bdlpv_pkg::VOL_CEIL) ? bdlpv_pkg::VOL_CEIL : max_reg;
        up_sum  = {1'b0, volume_reg} + {1'b0, step_reg};
        vol_up  = volume_reg;
        if (up_st.press) begin
            vol_up = (up_sum > {1'b0, top_vol}) ? top_vol : up_sum[3:0];
        end
        volume_next = vol_up;
        if (dn_st.press) begin
            volume_next = (step_reg >= vol_up) ? 4'd0 : vol_up - step_reg;
        end
    end

    always_comb begin
        out_item_next.volume_level        = volume_next;
        out_item_next.system_active       = active_next;
        out_item_next.power_toggled       = toggle;
        out_item_next.volume_up_pressed   = up_st.press;
        out_item_next.volume_down_pressed = dn_st.press;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_time_reg <= '0;
            long_done_reg  <= 1'b0;
            active_reg     <= 1'b1;
            volume_reg     <= bdlpv_pkg::VOL_RESET;
        end else if (fire) begin
            press_time_reg <= press_time_next;
            long_done_reg  <= long_done_next;
            active_reg     <= active_next;
            volume_reg     <= volume_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bdlpv_pkg::DEBOUNCE_RESET;
            hold_reg     <= bdlpv_pkg::HOLD_RESET;
            step_reg     <= bdlpv_pkg::STEP_RESET;
            max_reg      <= bdlpv_pkg::MAX_RESET;
        end else if (cfg_wr_en) begin
            unique case (bdlpv_pkg::cfg_reg_t'(cfg_addr))
                bdlpv_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data[7:0];
                bdlpv_pkg::REG_HOLD:     hold_reg     <= cfg_data;
                bdlpv_pkg::REG_STEP:     step_reg     <= cfg_data[3:0];
                bdlpv_pkg::REG_MAX:      max_reg      <= cfg_data[3:0];
                default:                 max_reg      <= max_reg;
            endcase
        end
    end

endmodule

/* design/bdlpv_checker.sv */
// ----------------------------------------------------------------------------
// Button debounce / long press / volume: port checker
// Watches the top-level ports and is bound to every instance.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_volume_defines.svh"

module bdlpv_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input bdlpv_pkg::in_item_t                   s_data,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input bdlpv_pkg::out_item_t                  m_data,
    input logic                                  cfg_wr_en,
    input logic [bdlpv_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input logic [bdlpv_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    `BDLPV_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    `BDLPV_ASSERT(a_volume_range, m_valid |-> m_data.volume_level <= bdlpv_pkg::VOL_CEIL, "volume above ceiling")

    `BDLPV_ASSERT(a_backpressure, m_valid && !m_ready && s_valid && s_ready ##1 !m_ready |-> !s_ready, "request taken with both stages full")

endmodule

bind button_debounce_long_press_volume bdlpv_checker u_bdlpv_checker (.*);

/* tb/tb_button_debounce_long_press_volume.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: button debounce, long-press power toggle, stepped volume
// Drives button samples over a valid/ready channel with random gaps and
// result back-pressure. A directed table checks the reset state, debounce
// edges, long presses, wrapping timestamps and the odd register settings.
// Random phases under several register settings follow; their results are
// compared against a local model of the debounce and volume logic.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_volume;
    import bdlpv_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        bit          is_cfg;
        in_item_t    smp;
        bit          typed;
        out_item_t   want;
        logic [7:0]  deb;
        logic [15:0] hold;
        logic [3:0]  step;
        logic [3:0]  vmax;
    } plan_row_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    in_item_t                  s_data = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    out_item_t                 m_data;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

    // model of the block
    logic [7:0]  lim_debounce;
    logic [15:0] lim_hold;
    logic [3:0]  lim_step;
    logic [3:0]  lim_vmax;
    logic [2:0]  btn_stable;
    logic [31:0] btn_since [3];
    logic [31:0] press_at;
    logic        hold_done;
    logic        is_active;
    logic [3:0]  vol_now;

    out_item_t   status_due [$];
    plan_row_t   plan [$];

    bit calm = 1'b0;
    int mismatches = 0;
    int samples_sent = 0;
    int status_seen = 0;
    int settings_used = 1;
    int toggles_seen = 0;
    int ups_seen = 0;
    int downs_seen = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    button_debounce_long_press_volume uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void reset_model();
        lim_debounce = DEBOUNCE_RESET;
        lim_hold     = HOLD_RESET;
        lim_step     = STEP_RESET;
        lim_vmax     = MAX_RESET;
        btn_stable   = 3'b111;
        for (int i = 0; i < 3; i++) btn_since[i] = '0;
        press_at  = '0;
        hold_done = 1'b0;
        is_active = 1'b1;
        vol_now   = VOL_RESET;
    endfunction

    // returns 1 when the stable level of button idx moved on this sample
    function automatic bit settle_btn(int idx, logic raw, logic [31:0] now);
        logic [31:0] since;
        since = now - btn_since[idx];
        if (raw != btn_stable[idx]) begin
            if (since >= {24'd0, lim_debounce}) begin
                btn_stable[idx] = raw;
                btn_since[idx]  = now;
                return 1'b1;
            end
        end else begin
            btn_since[idx] = now;
        end
        return 1'b0;
    endfunction

    function automatic out_item_t next_status(in_item_t smp);
        out_item_t   st;
        int          top;
        int          sum;
        logic [31:0] held_for;
        st  = '0;
        top = (lim_vmax > VOL_CEIL) ? VOL_CEIL : lim_vmax;
        if (settle_btn(0, smp.power_level, smp.now_ms) && !btn_stable[0]) begin
            press_at  = smp.now_ms;
            hold_done = 1'b0;
        end
        held_for = smp.now_ms - press_at;
        if (!btn_stable[0] && !hold_done && held_for >= {16'd0, lim_hold}) begin
            hold_done = 1'b1;
            is_active = ~is_active;
            st.power_toggled = 1'b1;
        end
        if (settle_btn(1, smp.up_level, smp.now_ms) && !btn_stable[1]) begin
            sum = vol_now + lim_step;
            vol_now = 4'((sum > top) ? top : sum);
            st.volume_up_pressed = 1'b1;
        end
        if (settle_btn(2, smp.down_level, smp.now_ms) && !btn_stable[2]) begin
            vol_now = (lim_step >= vol_now) ? 4'd0 : vol_now - lim_step;
            st.volume_down_pressed = 1'b1;
        end
        st.volume_level  = vol_now;
        st.system_active = is_active;
        return st;
    endfunction

    function automatic void add_sample(bit p, bit u, bit d, logic [31:0] now);
        plan_row_t row;
        row = '0;
        row.smp = {p, u, d, now};
        plan.push_back(row);
    endfunction

    function automatic void add_checked(bit p, bit u, bit d, logic [31:0] now,
                                        int vol, bit act, bit tog, bit upf, bit dnf);
        plan_row_t row;
        row = '0;
        row.smp   = {p, u, d, now};
        row.typed = 1'b1;
        row.want  = {vol[3:0], act, tog, upf, dnf};
        plan.push_back(row);
    endfunction

    function automatic void add_setting(int deb, int hold, int step, int vmax);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.deb    = 8'(deb);
        row.hold   = 16'(hold);
        row.step   = 4'(step);
        row.vmax   = 4'(vmax);
        plan.push_back(row);
    endfunction

    function automatic void build_plan();
        // reset values, up debounce with a bounce, saturation at the top
        add_checked(1, 1, 1, 32'd0,    8, 1, 0, 0, 0);
        add_checked(1, 0, 1, 32'd10,   8, 1, 0, 0, 0);
        add_checked(1, 0, 1, 32'd45,   9, 1, 0, 1, 0);
        add_checked(1, 1, 1, 32'd46,   9, 1, 0, 0, 0);
        add_checked(1, 1, 1, 32'd80,   9, 1, 0, 0, 0);
        add_checked(1, 0, 1, 32'd200, 10, 1, 0, 1, 0);
        add_checked(1, 1, 1, 32'd300, 10, 1, 0, 0, 0);
        add_checked(1, 0, 1, 32'd400, 10, 1, 0, 1, 0);
        add_checked(1, 1, 0, 32'd500,  9, 1, 0, 0, 1);
        // long press: one ms short, exact, then held on without a second toggle
        add_checked(0, 1, 1, 32'd600,  9, 1, 0, 0, 0);
        add_checked(0, 1, 1, 32'd2599, 9, 1, 0, 0, 0);
        add_checked(0, 1, 1, 32'd2600, 9, 0, 1, 0, 0);
        add_checked(0, 1, 1, 32'd9000, 9, 0, 0, 0, 0);
        add_checked(1, 1, 1, 32'd9100, 9, 0, 0, 0, 0);
        // timestamps wrapping through zero
        add_sample(1, 1, 1, 32'hFFFF_FFF0);
        add_checked(1, 0, 0, 32'h0000_0010, 9, 0, 0, 0, 0);
        add_checked(1, 0, 0, 32'h0000_0013, 9, 0, 0, 1, 1);
        add_sample(0, 1, 1, 32'h7FFF_FFFF);
        add_checked(0, 1, 1, 32'h8000_07CF, 9, 1, 1, 0, 0);
        add_checked(1, 1, 1, 32'hFFFF_FFFF, 9, 1, 0, 0, 0);
        // no debounce, no hold, zero step, maximum above ten
        add_setting(0, 0, 0, 15);
        add_checked(0, 1, 1, 32'd5,  9, 0, 1, 0, 0);
        add_checked(0, 0, 1, 32'd5,  9, 0, 0, 1, 0);
        // step larger than the volume both ways
        add_setting(0, 0, 15, 15);
        add_checked(0, 1, 0, 32'd6,  0, 0, 0, 0, 1);
        add_checked(0, 0, 1, 32'd7, 10, 0, 0, 1, 0);
        // volume left above a lowered maximum
        add_setting(0, 0, 1, 3);
        add_checked(0, 1, 0, 32'd8,  9, 0, 0, 0, 1);
        add_checked(0, 0, 1, 32'd9,  3, 0, 0, 1, 0);
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a rising edge; returns at the edge the request is taken
    task automatic send_sample(in_item_t smp, bit typed, out_item_t want);
        int        gap;
        out_item_t st;
        gap = idle_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        do @(posedge aclk); while (!s_ready);
        st = next_status(smp);
        status_due.push_back(typed ? want : st);
        samples_sent++;
    endtask

    task automatic wait_drained();
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    // narrow registers get junk in the unused upper data bits
    task automatic program_regs(logic [7:0] deb, logic [15:0] hold,
                                logic [3:0] step, logic [3:0] vmax);
        logic [11:0] junk;
        junk = 12'($urandom);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DEBOUNCE;
        cfg_data  <= {junk[7:0], deb};
        @(posedge aclk);
        cfg_addr  <= REG_HOLD;
        cfg_data  <= hold;
        @(posedge aclk);
        cfg_addr  <= REG_STEP;
        cfg_data  <= {junk, step};
        @(posedge aclk);
        junk = 12'($urandom);
        cfg_addr  <= REG_MAX;
        cfg_data  <= {junk, vmax};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        lim_debounce = deb;
        lim_hold     = hold;
        lim_step     = step;
        lim_vmax     = vmax;
        settings_used++;
    endtask

    // held presses with bounce and irregular time steps, some pure noise
    task automatic random_phase(int count);
        logic [2:0]  held;
        logic [31:0] t;
        in_item_t    smp;
        out_item_t   no_want;
        int          r;
        int          span;
        no_want = '0;
        held = 3'b111;
        if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        else t = $urandom;
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 8) begin
                smp.now_ms = $urandom;
                {smp.power_level, smp.up_level, smp.down_level} = 3'($urandom);
            end else begin
                for (int b = 0; b < 3; b++)
                    if ($urandom_range(0, 15) == 0) held[b] = ~held[b];
                r = $urandom_range(0, 99);
                if (r < 45) span = 8;
                else if (r < 85) span = lim_debounce + lim_debounce / 2 + 4;
                else if (r < 97) span = lim_hold / 8 + 50;
                else span = lim_hold + 100;
                t = t + $urandom_range(0, span);
                smp.power_level = held[0] ^ ($urandom_range(0, 9) == 0);
                smp.up_level    = held[1] ^ ($urandom_range(0, 9) == 0);
                smp.down_level  = held[2] ^ ($urandom_range(0, 9) == 0);
                smp.now_ms      = t;
            end
            send_sample(smp, 1'b0, no_want);
        end
        calm = 1'b0;
    endtask

    task automatic check_field(string what, logic [3:0] want, logic [3:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 100)
                $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_len() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            status_seen++;
            toggles_seen += m_data.power_toggled;
            ups_seen     += m_data.volume_up_pressed;
            downs_seen   += m_data.volume_down_pressed;
            if (status_due.size() == 0) begin
                mismatches++;
                $display("%0t ns: result with none expected, got %h", $time, m_data);
            end else begin
                want = status_due.pop_front();
                check_field("volume_level", want.volume_level, m_data.volume_level);
                check_field("system_active", want.system_active, m_data.system_active);
                check_field("power_toggled", want.power_toggled, m_data.power_toggled);
                check_field("volume_up_pressed", want.volume_up_pressed,
                            m_data.volume_up_pressed);
                check_field("volume_down_pressed", want.volume_down_pressed,
                            m_data.volume_down_pressed);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no request moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL button_debounce_long_press_volume");
            $finish;
        end
    end

    initial begin
        plan_row_t row;
        int        directed;
        reset_model();
        build_plan();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < plan.size(); i++) begin
            row = plan[i];
            if (row.is_cfg) begin
                s_valid <= 1'b0;
                wait_drained();
                program_regs(row.deb, row.hold, row.step, row.vmax);
            end else begin
                send_sample(row.smp, row.typed, row.want);
            end
        end
        directed = samples_sent;

        for (int p = 0; p < 8; p++) begin
            s_valid <= 1'b0;
            wait_drained();
            case (p)
                0: program_regs(8'd35, 16'd2000, 4'd1, 4'd10);
                1: program_regs(8'd0, 16'd0, 4'd0, 4'd15);
                2: program_regs(8'd255, 16'd65535, 4'd15, 4'd0);
                3: program_regs(8'd10, 16'd300, 4'd3, 4'd7);
                4: program_regs(8'd0, 16'd1, 4'd10, 4'd1);
                default: program_regs(8'($urandom_range(0, 255)),
                                      16'($urandom_range(0, 4000)),
                                      4'($urandom_range(0, 15)),
                                      4'($urandom_range(0, 15)));
            endcase
            random_phase(PHASE_ITEMS);
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge aclk);

        $display("Sent %0d button samples (%0d directed) under %0d register settings;",
                 samples_sent, directed, settings_used);
        $display("%0d results checked, carrying %0d power toggles, %0d up and %0d down presses.",
                 status_seen, toggles_seen, ups_seen, downs_seen);
        if (mismatches == 0) begin
            $display("PASS button_debounce_long_press_volume");
        end else begin
            $display("FAIL button_debounce_long_press_volume");
        end
        $finish;
    end

endmodule
